### hdl/playback_clock_speed_pause_unit_assert.svh
// Assertion helpers shared by the playback clock RTL.
// Both macros expect i_clk and i_rst_n to exist in the enclosing module.
`ifndef PLAYBACK_CLOCK_SPEED_PAUSE_UNIT_ASSERT_SVH
`define PLAYBACK_CLOCK_SPEED_PAUSE_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PCSP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PCSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pcsp_pkg.sv
`timescale 1ns / 1ps

package pcsp_pkg;

    localparam int unsigned FUNC_W          = 3;
    localparam int unsigned COUNT_W         = 63;
    localparam int unsigned SPEED_W         = 8;
    localparam int unsigned PTS_W           = 48;
    localparam int unsigned CLOCK_VALUE_W   = 48;
    localparam int unsigned CFG_W           = 32;
    localparam int unsigned START_W         = 64;
    localparam int unsigned TIME_BASE_DEF   = 1000000;
    localparam int unsigned CLOCK_WIDTH_DEF = 48;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1000000);

    typedef enum logic [FUNC_W-1:0] {
        FN_READ       = 3'd0,
        FN_SPEED      = 3'd1,
        FN_FULL_DISC  = 3'd2,
        FN_NORM_DISC  = 3'd3,
        FN_PAUSE      = 3'd4,
        FN_RESUME     = 3'd5,
        FN_DISC_CHECK = 3'd6
    } t_func;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [COUNT_W-1:0]       counter_now;
        logic signed [SPEED_W-1:0] speed;
        logic signed [PTS_W-1:0]  pts;
        logic signed [PTS_W-1:0]  delay;
    } t_in_item;

    typedef struct packed {
        logic signed [CLOCK_VALUE_W-1:0] clock_value;
        logic                            recent_discontinuity;
        logic                            bad_speed;
    } t_out_item;

endpackage

### hdl/playback_clock_speed_pause_unit.sv
`timescale 1ns / 1ps
`include "playback_clock_speed_pause_unit_assert.svh"

// Media playback clock. Each input beat carries a raw counter reading and one
// operation (read, set speed, full or normal discontinuity, pause, resume,
// discontinuity check); each input beat produces exactly one output beat with
// the clock value after the operation and two flags.
// Channels: input beat on i_in_valid/o_in_ready, output beat on
// o_out_valid/i_out_ready. The user must write the counter frequency register
// with i_cfg_we/i_cfg_data while no beat is in flight; it is not enforced.
// When the clock is frozen or waiting for a rebase, the peek state sends the
// beat straight to the finish state with no formula evaluation.
// A formula evaluation runs the shared bit-serial multiply/divide unit once,
// a multiply phase followed by a divide phase. A set speed with a nonzero
// speed first runs the unit twice more, to divide and then to multiply.
// One beat is worked on at a time; the unit sets the throughput of the
// beats that use it.
// The next input beat is taken while a finished result still waits in the
// output register; a stalled receiver only holds the block once the next
// result is ready. Reset puts the clock in the rebase-pending state with the
// counter frequency at its default and no output beat pending.
module playback_clock_speed_pause_unit
    import pcsp_pkg::*;
#(
    parameter int unsigned TIME_BASE   = TIME_BASE_DEF,
    parameter int unsigned CLOCK_WIDTH = CLOCK_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data
);

    localparam int unsigned CW     = CLOCK_WIDTH;
    localparam int unsigned TB_W   = $clog2(TIME_BASE + 1);
    localparam int unsigned MB_W   = (TB_W > CFG_W) ? TB_W : CFG_W;
    localparam int unsigned PROD_W = START_W + MB_W;
    localparam int unsigned SUM_W  = PROD_W + 2;
    localparam int unsigned UF_W   = CFG_W + 1;
    localparam int unsigned CMP_W  = (CW > PTS_W + 1) ? CW : PTS_W + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_OP, S_SPD_DIV, S_SPD_MUL, S_PEEK, S_FORM, S_FIN
    } t_state;

    t_state                   r_state;
    t_in_item                 r_item;
    logic [CFG_W-1:0]         r_cf;
    logic [START_W-1:0]       r_start;
    logic signed [UF_W-1:0]   r_uf;
    logic signed [PTS_W-1:0]  r_offset;
    logic signed [CW-1:0]     r_frozen;
    logic                     r_pending;
    logic                     r_bad;
    logic [CFG_W-1:0]         r_m;
    logic signed [CW-1:0]     r_clock;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic                     frozen_pos;
    logic [START_W-1:0]       diff;
    logic [START_W-1:0]       diff_mag;
    logic [CFG_W-1:0]         uf_mag;
    logic [SPEED_W-1:0]       spd_mag;
    logic                     md_start;
    logic [START_W-1:0]       md_a;
    logic [MB_W-1:0]          md_b;
    logic [CFG_W-1:0]         md_d;
    logic                     md_done;
    logic [PROD_W-1:0]        md_quot;
    logic                     set_neg;
    logic [START_W-1:0]       set_q;
    logic [START_W-1:0]       set_lo;
    logic                     form_neg;
    logic signed [SUM_W-1:0]  form_off;
    logic signed [SUM_W-1:0]  form_q;
    logic signed [SUM_W-1:0]  form_sum;
    logic [SUM_W-CW:0]        form_top;
    logic signed [CW-1:0]     n_form_clock;
    logic signed [PTS_W:0]    disc_sum;
    logic signed [CMP_W-1:0]  disc_cmp;
    logic signed [CMP_W-1:0]  clock_cmp;
    logic                     n_disc;
    logic signed [START_W-1:0] clock_ext;
    logic                     out_free;

    assign frozen_pos = (r_frozen != '0) && !r_frozen[CW-1];
    assign diff       = START_W'(r_item.counter_now) - r_start;
    assign diff_mag   = diff[START_W-1] ? -diff : diff;
    assign uf_mag     = r_uf[UF_W-1] ? CFG_W'(-r_uf) : CFG_W'(r_uf);
    assign spd_mag    = r_item.speed[SPEED_W-1] ? SPEED_W'(-r_item.speed)
                                                : SPEED_W'(r_item.speed);

    // Operand selection for the shared unit.
    always_comb begin
        md_start = 1'b0;
        md_a     = diff_mag;
        md_b     = MB_W'(TIME_BASE);
        md_d     = uf_mag;
        case (r_state)
            S_OP: begin
                md_start = (r_item.func == FN_SPEED) && (r_item.speed != '0);
                md_a     = START_W'(r_cf);
                md_b     = MB_W'(1);
                md_d     = CFG_W'(spd_mag);
            end
            S_SPD_DIV: begin
                md_start = md_done;
                md_b     = MB_W'(md_quot[CFG_W-1:0]);
            end
            S_PEEK: begin
                md_start = !frozen_pos && !r_pending;
            end
            default: begin
                md_start = 1'b0;
            end
        endcase
    end

    pcsp_muldiv #(
        .A_W (START_W),
        .B_W (MB_W),
        .D_W (CFG_W)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (md_start),
        .i_a     (md_a),
        .i_b     (md_b),
        .i_d     (md_d),
        .o_done  (md_done),
        .o_quot  (md_quot)
    );

    // New start point for a speed change; only the low word of the signed
    // quotient matters since the start point wraps.
    assign set_neg = r_item.speed[SPEED_W-1] ^ diff[START_W-1] ^ r_uf[UF_W-1];
    assign set_q   = md_quot[START_W-1:0];
    assign set_lo  = set_neg ? -set_q : set_q;

    // Clock formula: offset plus or minus the quotient, then saturate.
    assign form_neg     = diff[START_W-1] ^ r_uf[UF_W-1];
    assign form_off     = SUM_W'(r_offset);
    assign form_q       = $signed({2'b00, md_quot});
    assign form_sum     = form_neg ? (form_off - form_q) : (form_off + form_q);
    assign form_top     = form_sum[SUM_W-1:CW-1];
    assign n_form_clock = ((&form_top) || !(|form_top)) ? form_sum[CW-1:0]
                        : (form_sum[SUM_W-1] ? {1'b1, {(CW-1){1'b0}}}
                                             : {1'b0, {(CW-1){1'b1}}});

    assign disc_sum  = (PTS_W + 1)'(r_offset) + (PTS_W + 1)'(r_item.delay);
    assign disc_cmp  = CMP_W'(disc_sum);
    assign clock_cmp = CMP_W'(r_clock);
    assign n_disc    = disc_cmp > clock_cmp;

    assign clock_ext = START_W'(r_clock);
    assign out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cf        <= CFG_RESET;
            r_start     <= '0;
            r_uf        <= $signed({1'b0, CFG_RESET});
            r_offset    <= '0;
            r_frozen    <= '0;
            r_pending   <= 1'b1;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cf <= i_cfg_data;
            end
            // In the finish state a taken beat is replaced by the new one below.
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_bad   <= 1'b0;
                        r_state <= S_OP;
                    end
                end
                S_OP: begin
                    if ((r_item.func == FN_SPEED) && (r_item.speed != '0)) begin
                        r_state <= S_SPD_DIV;
                    end else begin
                        r_state <= S_PEEK;
                    end
                    case (t_func'(r_item.func))
                        FN_READ, FN_PAUSE, FN_DISC_CHECK: begin
                            // A pending rebase takes effect on the first read, pause or check while not frozen.
                            if (!frozen_pos && r_pending) begin
                                r_start   <= START_W'(r_item.counter_now);
                                r_uf      <= $signed({1'b0, r_cf});
                                r_offset  <= '0;
                                r_frozen  <= '0;
                                r_pending <= 1'b0;
                            end
                        end
                        FN_SPEED: begin
                            if (r_item.speed == '0) begin
                                r_bad <= 1'b1;
                            end
                        end
                        FN_FULL_DISC: begin
                            r_pending <= 1'b1;
                        end
                        FN_NORM_DISC: begin
                            r_start  <= START_W'(r_item.counter_now);
                            r_offset <= r_item.pts;
                        end
                        FN_RESUME: begin
                            r_pending <= 1'b1;
                            r_frozen  <= '0;
                        end
                        default: begin
                        end
                    endcase
                end
                S_SPD_DIV: begin
                    if (md_done) begin
                        r_m     <= md_quot[CFG_W-1:0];
                        r_state <= S_SPD_MUL;
                    end
                end
                S_SPD_MUL: begin
                    if (md_done) begin
                        r_start <= START_W'(r_item.counter_now) - set_lo;
                        r_uf    <= r_item.speed[SPEED_W-1] ? -$signed({1'b0, r_m})
                                                           : $signed({1'b0, r_m});
                        r_state <= S_PEEK;
                    end
                end
                S_PEEK: begin
                    if (frozen_pos) begin
                        r_clock <= r_frozen;
                        r_state <= S_FIN;
                    end else if (r_pending) begin
                        r_clock <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_FORM;
                    end
                end
                S_FORM: begin
                    if (md_done) begin
                        r_clock <= n_form_clock;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid                <= 1'b1;
                        r_out.clock_value          <= clock_ext[CLOCK_VALUE_W-1:0];
                        r_out.recent_discontinuity <= (r_item.func == FN_DISC_CHECK) && n_disc;
                        r_out.bad_speed            <= r_bad;
                        if (r_item.func == FN_PAUSE) begin
                            r_frozen <= r_clock;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PCSP_ASSERT_NEXT(a_accept_to_op, i_in_valid && o_in_ready, r_state == S_OP,
        "accepted beat did not enter dispatch")
    `PCSP_ASSERT_SAME(a_out_from_fin, $rose(o_out_valid), $past(r_state == S_FIN),
        "output beat raised outside the finish state")
    `PCSP_ASSERT_SAME(a_md_start_state, md_start,
        r_state == S_OP || r_state == S_SPD_DIV || r_state == S_PEEK,
        "arithmetic unit started from an unexpected state")

endmodule

### hdl/pcsp_muldiv.sv
`timescale 1ns / 1ps
`include "playback_clock_speed_pause_unit_assert.svh"

// Unsigned floor(a * b / d), one multiplier bit per cycle followed by one
// quotient bit per cycle. A zero divisor gives a zero quotient.
module pcsp_muldiv
    import pcsp_pkg::*;
#(
    parameter int unsigned A_W = START_W,
    parameter int unsigned B_W = CFG_W,
    parameter int unsigned D_W = CFG_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    input  logic [D_W-1:0]     i_d,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_quot
);

    localparam int unsigned P_W   = A_W + B_W;
    localparam int unsigned CNT_W = $clog2(P_W);

    typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} t_md_state;

    t_md_state        r_md_state;
    logic [P_W-1:0]   r_prod;
    logic [A_W-1:0]   r_a;
    logic [D_W-1:0]   r_d;
    logic [D_W-1:0]   r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic             r_dzero;

    logic [A_W:0]     mul_sum;
    logic [D_W:0]     div_trial;
    logic [D_W:0]     div_diff;
    logic             div_ge;

    // The product register shifts right while the partial sum enters at the top;
    // the same register then shifts left through the divider, quotient bits
    // entering at the bottom.
    assign mul_sum   = {1'b0, r_prod[P_W-1:B_W]} + (r_prod[0] ? {1'b0, r_a} : '0);
    assign div_trial = {r_rem, r_prod[P_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_d};
    assign div_diff  = div_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_md_state <= MD_IDLE;
            r_done     <= 1'b0;
        end else begin
            r_done <= (r_md_state == MD_DIV) && (r_cnt == CNT_W'(P_W - 1));
            case (r_md_state)
                MD_IDLE: begin
                    if (i_start) begin
                        r_prod     <= {{A_W{1'b0}}, i_b};
                        r_a        <= i_a;
                        r_d        <= i_d;
                        r_dzero    <= (i_d == '0);
                        r_cnt      <= '0;
                        r_md_state <= MD_MUL;
                    end
                end
                MD_MUL: begin
                    r_prod <= {mul_sum, r_prod[B_W-1:1]};
                    if (r_cnt == CNT_W'(B_W - 1)) begin
                        r_cnt      <= '0;
                        r_rem      <= '0;
                        r_md_state <= MD_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                MD_DIV: begin
                    r_rem  <= div_ge ? div_diff[D_W-1:0] : div_trial[D_W-1:0];
                    r_prod <= {r_prod[P_W-2:0], div_ge};
                    if (r_cnt == CNT_W'(P_W - 1)) begin
                        r_md_state <= MD_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_md_state <= MD_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dzero ? '0 : r_prod;

    `PCSP_ASSERT_SAME(a_start_when_idle, i_start, r_md_state == MD_IDLE, "start while busy")
    `PCSP_ASSERT_SAME(a_done_after_div, o_done, $past(r_md_state == MD_DIV), "stray done")
    `PCSP_ASSERT_NEXT(a_mul_to_div, r_md_state == MD_MUL && r_cnt == CNT_W'(B_W - 1),
        r_md_state == MD_DIV && r_cnt == '0, "multiply did not hand over to divide")

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pcsp_pkg::*;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    t_in_item         i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_item        o_out_data;

    // Copy of the clock state as the block should hold it.
    logic [CFG_W-1:0] freq_setting = CFG_RESET;
    logic [63:0]      clk_start = '0;
    logic [63:0]      clk_rate = 64'(CFG_RESET);
    logic [47:0]      clk_offset = '0;
    logic [47:0]      clk_frozen = '0;
    logic             clk_rebase = 1'b1;

    t_out_item        pending_clock_results[$];
    t_out_item        oldest_clock_result;
    logic [62:0]      counter_track = '0;
    logic             steady = 1'b0;
    int unsigned      mismatches = 0;
    int unsigned      beats_sent = 0;
    int unsigned      func_tally[8];
    int unsigned      zero_speed_seen = 0;
    int unsigned      disc_seen = 0;

    playback_clock_speed_pause_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Signed a*b/d truncated toward zero, as a 128-bit two's complement value.
    // A zero divisor yields zero.
    function automatic logic [127:0] signed_scale(input logic [63:0] a,
                                                  input logic [63:0] b,
                                                  input logic [63:0] d);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [63:0]  md;
        logic [127:0] q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        md = d[63] ? -d : d;
        q = (md == 64'd0) ? 128'd0 : ({64'd0, ma} * {64'd0, mb}) / {64'd0, md};
        return (a[63] ^ b[63] ^ d[63]) ? -q : q;
    endfunction

    function automatic logic [47:0] clock_from_counter(input logic [63:0] now);
        logic [127:0] v;
        v = signed_scale(now - clk_start, 64'(TIME_BASE_DEF), clk_rate)
            + {{80{clk_offset[47]}}, clk_offset};
        if (v[127:47] == '0 || v[127:47] == '1) return v[47:0];
        return v[127] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    endfunction

    function automatic logic frozen_counts();
        return clk_frozen != '0 && !clk_frozen[47];
    endfunction

    // Clock read that performs a pending rebase unless the clock is frozen.
    function automatic logic [47:0] settle_clock(input logic [63:0] now);
        if (frozen_counts()) return clk_frozen;
        if (clk_rebase) begin
            clk_start = now;
            clk_rate = {32'd0, freq_setting};
            clk_offset = '0;
            clk_frozen = '0;
            clk_rebase = 1'b0;
        end
        return clock_from_counter(now);
    endfunction

    function automatic t_out_item next_clock_beat(input t_in_item it);
        t_out_item         res;
        logic [63:0]       now;
        logic [63:0]       new_rate;
        logic [127:0]      q;
        logic [47:0]       c;
        logic signed [48:0] window;
        res = '0;
        now = {1'b0, it.counter_now};
        case (t_func'(it.func))
            FN_READ: void'(settle_clock(now));
            FN_SPEED: begin
                if (it.speed == '0) begin
                    res.bad_speed = 1'b1;
                end else begin
                    new_rate = {32'd0, freq_setting}
                               / {56'd0, (it.speed[7] ? -it.speed : it.speed)};
                    if (it.speed[7]) new_rate = -new_rate;
                    // Move the start point so the clock does not jump.
                    q = signed_scale(new_rate, now - clk_start, clk_rate);
                    clk_start = now - q[63:0];
                    clk_rate = new_rate;
                end
            end
            FN_FULL_DISC: clk_rebase = 1'b1;
            FN_NORM_DISC: begin
                clk_start = now;
                clk_offset = it.pts;
            end
            FN_PAUSE: clk_frozen = settle_clock(now);
            FN_RESUME: begin
                clk_rebase = 1'b1;
                clk_frozen = '0;
            end
            FN_DISC_CHECK: begin
                c = settle_clock(now);
                window = {clk_offset[47], clk_offset} + {it.delay[47], it.delay};
                res.recent_discontinuity = window > $signed({c[47], c});
            end
            default: ;
        endcase
        if (frozen_counts()) res.clock_value = clk_frozen;
        else if (clk_rebase) res.clock_value = '0;
        else res.clock_value = clock_from_counter(now);
        return res;
    endfunction

    function automatic t_in_item clock_beat(input t_func f, input logic [62:0] now,
                                            input logic [7:0] spd, input logic [47:0] pts,
                                            input logic [47:0] dly);
        t_in_item it;
        it.func = f;
        it.counter_now = now;
        it.speed = spd;
        it.pts = pts;
        it.delay = dly;
        return it;
    endfunction

    function automatic t_in_item random_beat();
        t_in_item    it;
        logic [63:0] wide;
        int          pick;
        wide = {$urandom, $urandom};
        // Mostly a counter that runs forward; now and then a jump or a step back.
        if ($urandom_range(99) < 4)
            counter_track = wide[62:0];
        else if ($urandom_range(99) < 3)
            counter_track = counter_track - 63'($urandom_range(2000));
        else
            counter_track = counter_track
                            + 63'({32'd0, $urandom} % (64'(freq_setting) * 3 + 1));
        it.counter_now = counter_track;
        pick = $urandom_range(99);
        if (pick < 28) it.func = FN_READ;
        else if (pick < 40) it.func = FN_SPEED;
        else if (pick < 46) it.func = FN_FULL_DISC;
        else if (pick < 56) it.func = FN_NORM_DISC;
        else if (pick < 68) it.func = FN_PAUSE;
        else if (pick < 78) it.func = FN_RESUME;
        else it.func = FN_DISC_CHECK;
        it.speed = ($urandom_range(99) < 8) ? 8'd0 : 8'(int'($urandom_range(128)) - 64);
        wide = {$urandom, $urandom};
        it.pts = ($urandom_range(4) == 0) ? wide[47:0] : {{16{wide[31]}}, wide[31:0]};
        wide = {$urandom, $urandom};
        case ($urandom_range(2))
            0: it.delay = wide[47:0];
            1: it.delay = {{16{wide[31]}}, wide[31:0]};
            default: it.delay = 48'(int'($urandom_range(4_000_000)) - 2_000_000);
        endcase
        return it;
    endfunction

    // Drives one beat and holds it until the block takes it.
    task automatic send_beat(input t_in_item it);
        int gap;
        i_in_data <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_clock_results.push_back(next_clock_beat(it));
        func_tally[it.func]++;
        beats_sent++;
        if (!steady && $urandom_range(99) < 21) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_clock_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_counter_frequency(input logic [CFG_W-1:0] f);
        i_cfg_data <= f;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        freq_setting = f;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_directed_cases();
        // Counter ticks are microseconds at the reset frequency.
        send_beat(clock_beat(FN_READ, 63'd5000, 8'd0, '0, '0));
        send_beat(clock_beat(FN_READ, 63'd1_005_000, 8'd0, '0, '0));
        send_beat(clock_beat(FN_DISC_CHECK, 63'd1_500_000, 8'd0, '0, 48'h7FFF_FFFF_FFFF));
        send_beat(clock_beat(FN_DISC_CHECK, 63'd1_600_000, 8'd0, '0, 48'h8000_0000_0000));
        send_beat(clock_beat(FN_SPEED, 63'd1_700_000, 8'd0, '0, '0));
        send_beat(clock_beat(FN_SPEED, 63'd2_000_000, 8'sh02, '0, '0));
        send_beat(clock_beat(FN_READ, 63'd3_000_000, 8'd0, '0, '0));
        send_beat(clock_beat(FN_SPEED, 63'd3_100_000, 8'shC0, '0, '0));
        send_beat(clock_beat(FN_SPEED, 63'd3_200_000, 8'sh40, '0, '0));
        send_beat(clock_beat(FN_SPEED, 63'd3_300_000, 8'sh01, '0, '0));
        send_beat(clock_beat(FN_PAUSE, 63'd4_000_000, 8'd0, '0, '0));
        send_beat(clock_beat(FN_READ, 63'd9_000_000, 8'd0, '0, '0));
        send_beat(clock_beat(FN_DISC_CHECK, 63'd9_100_000, 8'd0, '0, '0));
        send_beat(clock_beat(FN_RESUME, 63'd9_200_000, 8'd0, '0, '0));
        send_beat(clock_beat(FN_READ, 63'd9_500_000, 8'd0, '0, '0));
        send_beat(clock_beat(FN_NORM_DISC, 63'd9_600_000, 8'd0, 48'h7FFF_FFFF_FFFF, '0));
        send_beat(clock_beat(FN_READ, '1, 8'd0, '0, '0));
        send_beat(clock_beat(FN_NORM_DISC, 63'd0, 8'd0, 48'h8000_0000_0000, '0));
        // A negative clock is paused but the frozen value must not count.
        send_beat(clock_beat(FN_PAUSE, 63'd0, 8'd0, '0, '0));
        send_beat(clock_beat(FN_READ, 63'd5, 8'd0, '0, '0));
        send_beat(clock_beat(FN_FULL_DISC, 63'd100, 8'd0, '0, '0));
        send_beat(clock_beat(FN_DISC_CHECK, 63'd200, 8'd0, '0, '1));
        send_beat(clock_beat(FN_READ, 63'd0, 8'd0, '0, '0));
        send_beat(clock_beat(FN_READ, '1, 8'd0, '1, '1));
        drain_results();
    endtask

    task automatic run_frequency_sweep();
        logic [CFG_W-1:0] rates[6];
        rates = '{32'd1, 32'hFFFF_FFFF, 32'd90_000, 32'd27_000_000, $urandom, CFG_RESET};
        if (rates[4] == '0) rates[4] = 32'd1;
        foreach (rates[k]) begin
            drain_results();
            write_counter_frequency(rates[k]);
            repeat (120) send_beat(random_beat());
        end
        drain_results();
    endtask

    task automatic run_random_traffic();
        repeat (350) send_beat(random_beat());
        steady = 1'b1;
        repeat (250) send_beat(random_beat());
        steady = 1'b0;
        repeat (100) send_beat(random_beat());
        drain_results();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady || ($urandom_range(99) >= 21);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_clock_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 100)
                    $display("%0t: unexpected output beat, expected none, actual %h",
                             $time, o_out_data);
            end else begin
                oldest_clock_result = pending_clock_results.pop_front();
                if (o_out_data.clock_value !== oldest_clock_result.clock_value
                    || o_out_data.recent_discontinuity
                       !== oldest_clock_result.recent_discontinuity
                    || o_out_data.bad_speed !== oldest_clock_result.bad_speed) begin
                    mismatches++;
                    if (mismatches <= 100)
                        $display("%0t: expected clock %h disc %b bad %b, actual clock %h disc %b bad %b",
                                 $time, oldest_clock_result.clock_value,
                                 oldest_clock_result.recent_discontinuity,
                                 oldest_clock_result.bad_speed, o_out_data.clock_value,
                                 o_out_data.recent_discontinuity, o_out_data.bad_speed);
                end
                zero_speed_seen += oldest_clock_result.bad_speed;
                disc_seen += oldest_clock_result.recent_discontinuity;
            end
        end
    end

    initial begin
        #50_000_000;
        $display("playback_clock_speed_pause_unit: mismatch");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed_cases();
        run_frequency_sweep();
        run_random_traffic();
        repeat (450) @(posedge i_clk);
        mismatches += pending_clock_results.size();
        $display("Ran %0d beats over six counter frequencies: %0d reads, %0d speed sets, %0d pauses, %0d resumes, %0d checks.",
                 beats_sent, func_tally[FN_READ], func_tally[FN_SPEED], func_tally[FN_PAUSE],
                 func_tally[FN_RESUME], func_tally[FN_DISC_CHECK]);
        $display("Zero speed rejected %0d times, recent discontinuity flagged %0d times.",
                 zero_speed_seen, disc_seen);
        if (mismatches == 0)
            $display("playback_clock_speed_pause_unit: match");
        else
            $display("playback_clock_speed_pause_unit: mismatch");
        $finish;
    end

endmodule
